[design/bstk_pkg.sv]
// shared types, constants and codes for the bounded stack with search
package bstk_pkg;

    localparam int BSTK_DEPTH = 16;
    localparam int WORD_W     = 32;
    localparam int ACT_W      = 3;
    localparam int POS_W      = 5;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH     = 3'd0,
        ACT_POP      = 3'd1,
        ACT_PUSH_BOT = 3'd2,
        ACT_POP_BOT  = 3'd3,
        ACT_INSERT   = 3'd4,
        ACT_FIND     = 3'd5
    } bstk_action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } bstk_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_SHIFT_UP,
        ST_POP_WAIT,
        ST_BOT_POP,
        ST_SHIFT_DN,
        ST_SCAN,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_OUT
    } bstk_state_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [WORD_W-1:0] data_value;
        logic [POS_W-1:0]         position;
    } bstk_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        logic [COUNT_W-1:0]       match_count;
        logic                     found;
        logic signed [WORD_W-1:0] top_value;
        logic [COUNT_W-1:0]       occupancy;
        logic                     is_empty;
        logic [STATUS_W-1:0]      status;
    } bstk_rsp_t;

    typedef struct packed {
        logic         in_load;
        logic         res_clr;
        logic         mem_we;
        logic         wsel_req;
        logic         mem_re;
        logic         cnt_inc;
        logic         cnt_dec;
        logic         match_en;
        logic         pop_load;
        logic         top_load;
        logic         top_clr;
        logic         st_load;
        bstk_status_t st_code;
        logic         out_load;
    } bstk_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic             out_busy;
    } bstk_sts_t;

endpackage

[design/bstk_datapath.sv]
// stack memory, fill count, request and result registers
module bstk_datapath
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bstk_cmd_t                    cmd,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    output bstk_sts_t                    sts,
    output logic [$clog2(DEPTH+1)-1:0]   cnt,
    input  bstk_req_t                    req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output bstk_rsp_t                    rsp_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;
    bstk_req_t                req_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            match_reg;
    logic signed [WORD_W-1:0] popped_reg;
    logic signed [WORD_W-1:0] top_reg;
    bstk_status_t             status_reg;
    bstk_rsp_t                rsp_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] wdata;
    logic [XW-1:0]            match_x;
    logic [XW-1:0]            cnt_x;

    assign wdata = cmd.wsel_req ? req_reg.data_value : rdata_reg;

    // stack storage
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            req_reg <= req_data;
        end
        if (cmd.res_clr)
        begin
            match_reg  <= '0;
            popped_reg <= '0;
            status_reg <= STS_OK;
        end
        else
        begin
            if (cmd.match_en && rdata_reg == req_reg.data_value)
            begin
                match_reg <= match_reg + CW'(1);
            end
            if (cmd.pop_load)
            begin
                popped_reg <= rdata_reg;
            end
            if (cmd.st_load)
            begin
                status_reg <= cmd.st_code;
            end
        end
        if (cmd.top_clr)
        begin
            top_reg <= '0;
        end
        else if (cmd.top_load)
        begin
            top_reg <= rdata_reg;
        end
    end

    // result register
    assign match_x = XW'(match_reg);
    assign cnt_x   = XW'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.popped_value <= popped_reg;
            rsp_reg.match_count  <= match_x[COUNT_W-1:0];
            rsp_reg.found        <= (match_reg != '0);
            rsp_reg.top_value    <= top_reg;
            rsp_reg.occupancy    <= cnt_x[COUNT_W-1:0];
            rsp_reg.is_empty     <= (cnt_reg == '0);
            rsp_reg.status       <= status_reg;
        end
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign rsp_data     = rsp_reg;
    assign cnt          = cnt_reg;
    assign sts.action   = req_reg.action;
    assign sts.position = req_reg.position;
    assign sts.out_busy = out_valid_reg & rsp_stall;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> cnt_reg != FULL_CNT)
        else $error("write into full stack");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> cnt_reg != '0)
        else $error("removal from empty stack");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_we && cmd.mem_re) |-> waddr != raddr)
        else $error("read and write at one address");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && rsp_stall))
        else $error("result register overwritten while held");

endmodule

[design/bstk_ctrl.sv]
// sequencer that steps the datapath through each request
module bstk_ctrl
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  bstk_sts_t                    sts,
    input  logic [$clog2(DEPTH+1)-1:0]   cnt,
    output bstk_cmd_t                    cmd,
    output logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [$clog2(DEPTH)-1:0]     waddr
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bstk_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic          wpend_reg, wpend_next;
    logic          done_reg, done_next;

    logic [CW-1:0] cnt_m1;
    logic          full;
    logic          empty;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] ins_x;
    logic [CW-1:0] tgt_calc;

    assign cnt_m1 = cnt - CW'(1);
    assign full   = (cnt == FULL_CNT);
    assign empty  = (cnt == '0);
    assign pos_x  = XW'(sts.position);
    assign cnt_x  = XW'(cnt);
    assign ins_x  = cnt_x - pos_x;

    always_comb
    begin
        case (sts.action)
            ACT_PUSH_BOT: tgt_calc = '0;
            ACT_INSERT:   tgt_calc = (pos_x >= cnt_x) ? '0 : ins_x[CW-1:0];
            default:      tgt_calc = cnt;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            tgt_reg   <= '0;
            wptr_reg  <= '0;
            wpend_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tgt_reg   <= tgt_next;
            wptr_reg  <= wptr_next;
            wpend_reg <= wpend_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        tgt_next   = tgt_reg;
        wptr_next  = wptr_reg;
        wpend_next = wpend_reg;
        done_next  = done_reg;
        cmd        = '0;
        cmd.st_code = STS_OK;
        raddr      = idx_reg;
        waddr      = wptr_reg;
        req_stall  = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.in_load = 1'b1;
                    cmd.res_clr = 1'b1;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_TOP_RD;
                case (sts.action)
                    ACT_PUSH, ACT_PUSH_BOT, ACT_INSERT:
                    begin
                        if (full)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STS_FULL;
                        end
                        else
                        begin
                            tgt_next = tgt_calc[AW-1:0];
                            if (tgt_calc == cnt)
                            begin
                                state_next = ST_WRITE;
                            end
                            else
                            begin
                                idx_next   = cnt_m1[AW-1:0];
                                wpend_next = 1'b0;
                                done_next  = 1'b0;
                                state_next = ST_SHIFT_UP;
                            end
                        end
                    end
                    ACT_POP:
                    begin
                        if (empty)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.mem_re  = 1'b1;
                            raddr       = cnt_m1[AW-1:0];
                            cmd.cnt_dec = 1'b1;
                            state_next  = ST_POP_WAIT;
                        end
                    end
                    ACT_POP_BOT:
                    begin
                        if (empty)
                        begin
                            cmd.st_load = 1'b1;
                            cmd.st_code = STS_EMPTY;
                        end
                        else
                        begin
                            cmd.mem_re = 1'b1;
                            raddr      = '0;
                            state_next = ST_BOT_POP;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (!empty)
                        begin
                            idx_next   = '0;
                            wpend_next = 1'b0;
                            done_next  = 1'b0;
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_TOP_RD;
                    end
                endcase
            end

            ST_WRITE:
            begin
                cmd.mem_we   = 1'b1;
                cmd.wsel_req = 1'b1;
                waddr        = tgt_reg;
                cmd.cnt_inc  = 1'b1;
                state_next   = ST_TOP_RD;
            end

            // read one entry down while writing the previous one a place higher
            ST_SHIFT_UP:
            begin
                cmd.mem_we = wpend_reg;
                if (!done_reg)
                begin
                    cmd.mem_re = 1'b1;
                    wpend_next = 1'b1;
                    wptr_next  = idx_reg + AW'(1);
                    if (idx_reg == tgt_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = ST_WRITE;
                end
            end

            ST_POP_WAIT:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_TOP_RD;
            end

            ST_BOT_POP:
            begin
                cmd.pop_load = 1'b1;
                idx_next     = AW'(1);
                wpend_next   = 1'b0;
                done_next    = (cnt == CW'(1));
                state_next   = ST_SHIFT_DN;
            end

            // read one entry up while writing the previous one a place lower
            ST_SHIFT_DN:
            begin
                cmd.mem_we = wpend_reg;
                if (!done_reg)
                begin
                    cmd.mem_re = 1'b1;
                    wpend_next = 1'b1;
                    wptr_next  = idx_reg - AW'(1);
                    if (CW'(idx_reg) == cnt_m1)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    wpend_next  = 1'b0;
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_TOP_RD;
                end
            end

            ST_SCAN:
            begin
                cmd.match_en = wpend_reg;
                if (!done_reg)
                begin
                    cmd.mem_re = 1'b1;
                    wpend_next = 1'b1;
                    if (CW'(idx_reg) == cnt_m1)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = ST_TOP_RD;
                end
            end

            ST_TOP_RD:
            begin
                if (empty)
                begin
                    cmd.top_clr = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    cmd.mem_re = 1'b1;
                    raddr      = cnt_m1[AW-1:0];
                    state_next = ST_TOP_WAIT;
                end
            end

            ST_TOP_WAIT:
            begin
                cmd.top_load = 1'b1;
                state_next   = ST_OUT;
            end

            ST_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/bounded_stack_with_search.sv]
// top level of the bounded stack with bottom access, positional insert and search
//
// requests enter on req_valid/req_stall with a bstk_req_t payload; each one
// gives exactly one result on rsp_valid/rsp_stall with a bstk_rsp_t payload.
// an item is taken at a clock edge where valid is high and stall is low.
// one request is worked at a time: req_stall is low only while the sequencer
// is idle. the stack memory has one read and one write port, so the cost
// is set by how many entries a request moves or compares.
// push and pop touch only the top entry; a write into a full stack or a pop from
// an empty one sets the status and leaves the stack as it is. each request then
// reads the top entry, if any, for its result. push bottom, insert, pop bottom
// and find move or compare their entries one after another; an empty find has none.
// the next request can be taken in the cycle after the result is loaded.
// the result sits in an output register, so a stalled result stays put while
// the next request is taken and worked; that request then waits for the
// register before its result is loaded.
// reset clears the fill count and all control state; stack contents are not
// cleared and only written entries are ever read.
module bounded_stack_with_search
    import bstk_pkg::*;
#(
    parameter int DEPTH = BSTK_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  bstk_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output bstk_rsp_t rsp_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bstk_cmd_t     cmd;
    bstk_sts_t     sts;
    logic [CW-1:0] cnt;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;

    bstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cnt       (cnt),
        .cmd       (cmd),
        .raddr     (raddr),
        .waddr     (waddr)
    );

    bstk_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .raddr     (raddr),
        .waddr     (waddr),
        .sts       (sts),
        .cnt       (cnt),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
